/* sv/frcad_pkg.sv */
// Shared types and constants for the frame RMS change anomaly detector.
`timescale 1ns / 1ps
`default_nettype none
package frcad_pkg;

	localparam int FEATURE_W = 16;
	localparam int STEP_W    = 31;
	localparam int RMS_W     = 16;
	localparam int SUM_W     = 40;
	localparam int PROD_W    = 32;
	localparam int ROOT_W    = SUM_W + 1;
	localparam int ALU_W     = ROOT_W + 1;
	localparam int TOTAL_W   = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic signed [STEP_W:0] GATE_STEPS    = 32'sd50;
	localparam logic signed [STEP_W:0] HOLDOFF_STEPS = 32'sd100;
	localparam logic [STEP_W-1:0]      MIN_STEP      = 31'd100;
	localparam logic [TOTAL_W-1:0]     MAX_TOTAL     = 5'd20;
	localparam logic [RMS_W-1:0]       MIN_RMS       = 16'd128;
	localparam logic [RMS_W-1:0]       THRESH_RESET  = 16'd128;

	localparam logic REG_ERROR_THRESHOLD = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_ROOT,
		ST_GATE,
		ST_HOLD,
		ST_DONE
	} frcad_state_t;

endpackage
`default_nettype wire

/* sv/frcad_feature_if.sv */
// Feature input channel: valid/ready handshake with one feature per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface frcad_feature_if;
	import frcad_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [FEATURE_W-1:0] feature_value;
	logic                        frame_end;
	logic [STEP_W-1:0]           step_count;

	modport source(output valid, feature_value, frame_end, step_count, input ready);
	modport sink(input valid, feature_value, frame_end, step_count, output ready);
endinterface
`default_nettype wire

/* sv/frcad_result_if.sv */
// Result output channel: valid/ready handshake with one frame result per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface frcad_result_if;
	import frcad_pkg::*;

	logic             valid;
	logic             ready;
	logic [RMS_W-1:0] rms_error;
	logic             anomaly;
	logic             no_reference;

	modport source(output valid, rms_error, anomaly, no_reference, input ready);
	modport sink(input valid, rms_error, anomaly, no_reference, output ready);
endinterface
`default_nettype wire

/* sv/frame_rms_change_anomaly_detector_top.sv */
// Frame RMS change anomaly detector: top level with sequencer and shared adder.
//
// Usage: features stream in on the feature channel, one signed Q8.8 value per
// transfer, with frame_end on the last feature of a frame and the caller's step
// number. Each feature is compared against the same position of the previous
// frame; squared differences accumulate in a 40-bit saturating sum.
// A result transfer leaves on the result channel only for a frame_end feature.
// Each feature passes through memory read, square and accumulate steps; ready
// is high only while idle, so a feature is taken only after the last is through.
// A frame_end feature with a reference then goes to the root, which runs 21
// iterations through the one shared 42-bit adder, followed by the gate step, the
// holdoff step when the gate passes, and the load step into the result register.
// The first frame skips the root and gate steps and reports no_reference.
// The result register lets the next frame start while a result waits; a second
// result holds in the load step until the receiver takes the first.
// The threshold register sits at byte address 0 of the APB port; pready is
// always high. Reset clears the reference flag, counters, step marks and the
// threshold (to 0.5). The reference memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module frame_rms_change_anomaly_detector_top #(
	parameter int FRAME_FEATURES = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	frcad_feature_if.sink                    feature,
	frcad_result_if.source                   result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [frcad_pkg::ADDR_W-1:0] paddr,
	input  wire logic [frcad_pkg::DATA_W-1:0] pwdata,
	output logic      [frcad_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	import frcad_pkg::*;

	localparam int IDX_W = $clog2(FRAME_FEATURES);
	localparam int CNT_W = $clog2(FRAME_FEATURES + 1);
	localparam int SHIFT = CNT_W - 1;

	frcad_state_t state_q, state_d;

	logic [RMS_W-1:0]            thr_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        have_ref_q;
	logic signed [FEATURE_W-1:0] prev_frame_q [FRAME_FEATURES];
	logic signed [FEATURE_W-1:0] rd_q;
	logic signed [FEATURE_W-1:0] fv_q;
	logic                        last_q;
	logic                        use_q;
	logic [STEP_W-1:0]           step_q;
	logic [PROD_W-1:0]           prod_q;
	logic [SUM_W-1:0]            sum_q;
	logic [ROOT_W-1:0]           v_q;
	logic [ROOT_W-1:0]           res_q;
	logic [ROOT_W-1:0]           bit_q;
	logic [STEP_W-1:0]           gate_last_q;
	logic [STEP_W-1:0]           hold_last_q;
	logic [TOTAL_W-1:0]          total_q;
	logic                        anom_q;
	logic                        out_valid_q;
	logic [RMS_W-1:0]            out_rms_q;
	logic                        out_anom_q;
	logic                        out_noref_q;

	logic                        in_fire;
	logic                        in_use;
	logic [IDX_W-1:0]            in_idx;
	logic                        cfg_write;
	logic signed [FEATURE_W:0]   diff;
	logic signed [2*FEATURE_W+1:0] square;
	logic [ROOT_W-1:0]           alu_a;
	logic [ROOT_W-1:0]           alu_b;
	logic                        alu_sub;
	logic [ALU_W-1:0]            alu_y;
	logic [SUM_W-1:0]            sum_new;
	logic [RMS_W-1:0]            rms;
	logic [STEP_W:0]             gate_diff;
	logic [STEP_W:0]             hold_diff;
	logic                        gate_ok;
	logic                        hold_ok;
	logic                        out_free;

	assign in_fire   = feature.valid && feature.ready;
	assign in_use    = cnt_q < CNT_W'(FRAME_FEATURES);
	assign in_idx    = cnt_q[IDX_W-1:0];
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1] == REG_ERROR_THRESHOLD);

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_ERROR_THRESHOLD)
		? {{(DATA_W-RMS_W){1'b0}}, thr_q} : '0;

	assign diff   = {fv_q[FEATURE_W-1], fv_q} - {rd_q[FEATURE_W-1], rd_q};
	assign square = diff * diff;

	assign alu_y   = {1'b0, alu_a} + ({1'b0, alu_b} ^ {ALU_W{alu_sub}})
		+ ALU_W'(alu_sub);
	assign sum_new = alu_y[SUM_W] ? {SUM_W{1'b1}} : alu_y[SUM_W-1:0];

	assign rms = (|res_q[ROOT_W-1:RMS_W]) ? {RMS_W{1'b1}} : res_q[RMS_W-1:0];

	assign gate_diff = {1'b0, step_q} - {1'b0, gate_last_q};
	assign hold_diff = {1'b0, step_q} - {1'b0, hold_last_q};
	assign gate_ok   = (rms > thr_q) && ($signed(gate_diff) > GATE_STEPS);
	assign hold_ok   = !($signed(hold_diff) < HOLDOFF_STEPS) && (total_q <= MAX_TOTAL)
		&& (step_q >= MIN_STEP) && (rms >= MIN_RMS);

	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC: begin
				if (!last_q) state_d = ST_IDLE;
				else if (have_ref_q) state_d = ST_ROOT;
				else state_d = ST_DONE;
			end
			ST_ROOT: if (bit_q[0]) state_d = ST_GATE;
			ST_GATE: state_d = gate_ok ? ST_HOLD : ST_DONE;
			ST_HOLD: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		feature.ready = 1'b0;
		alu_a         = {1'b0, sum_q};
		alu_b         = {{(ROOT_W-PROD_W){1'b0}}, prod_q};
		alu_sub       = 1'b0;
		unique case (state_q)
			ST_IDLE: feature.ready = 1'b1;
			ST_ROOT: begin
				alu_a   = v_q;
				alu_b   = res_q | bit_q;
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q <= prev_frame_q[in_idx];
			if (in_use) prev_frame_q[in_idx] <= feature.feature_value;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					fv_q   <= feature.feature_value;
					last_q <= feature.frame_end;
					step_q <= feature.step_count;
					use_q  <= in_use;
				end
			end
			ST_MUL: prod_q <= (use_q && have_ref_q) ? square[PROD_W-1:0] : '0;
			ST_ACC: begin
				v_q    <= ROOT_W'(sum_new >> SHIFT);
				res_q  <= '0;
				bit_q  <= {1'b1, {(ROOT_W-1){1'b0}}};
				anom_q <= 1'b0;
			end
			ST_ROOT: begin
				if (!alu_y[ALU_W-1]) begin
					v_q   <= alu_y[ROOT_W-1:0];
					res_q <= (res_q >> 1) | bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_HOLD: if (hold_ok) anom_q <= 1'b1;
			ST_DONE: begin
				if (out_free) begin
					out_rms_q   <= have_ref_q ? rms : '0;
					out_anom_q  <= have_ref_q && anom_q;
					out_noref_q <= !have_ref_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THRESH_RESET;
			cnt_q       <= '0;
			have_ref_q  <= 1'b0;
			sum_q       <= '0;
			gate_last_q <= '0;
			hold_last_q <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) thr_q <= pwdata[RMS_W-1:0];
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_fire && in_use) cnt_q <= cnt_q + CNT_W'(1);
				ST_ACC:  sum_q <= sum_new;
				ST_GATE: if (gate_ok) gate_last_q <= step_q;
				ST_HOLD: begin
					if (hold_ok) begin
						hold_last_q <= step_q;
						total_q     <= total_q + TOTAL_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						have_ref_q  <= 1'b1;
						cnt_q       <= '0;
						sum_q       <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.rms_error    = out_rms_q;
	assign result.anomaly      = out_anom_q;
	assign result.no_reference = out_noref_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the frame RMS change anomaly detector top level.
`timescale 1ns / 1ps
module testbench;
	import frcad_pkg::*;

	localparam int FRAME_FEATURES = 64;
	localparam int MEAN_SHIFT = $clog2(FRAME_FEATURES + 1) - 1;
	localparam longint unsigned SQ_SUM_MAX = (64'd1 << SUM_W) - 64'd1;
	localparam longint STEP_LIMIT = (64'd1 << STEP_W) - 1;
	localparam logic [STEP_W-1:0] HIGH_STEP_BASE = 31'h7FFF_F000;
	localparam int GATE_SPAN = 50;
	localparam int HOLDOFF_SPAN = 100;
	localparam int EARLY_STEP = 100;
	localparam int CAP_TOTAL = 20;
	localparam int MIN_ERROR = 128;
	localparam int REG_STRIDE = 4;
	localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = ADDR_W'(REG_STRIDE * REG_ERROR_THRESHOLD);
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(REG_STRIDE);
	localparam int MAX_GAP = 30;
	localparam int SETTLE_CYCLES = 40;
	localparam int DIRECTED_ROWS = 10;
	localparam int SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 120;
	localparam int SEGMENT_FRAMES = 8;
	localparam int LIMIT_NS = 5_000_000;

	typedef struct packed {
		logic [RMS_W-1:0] rms_error;
		logic             anomaly;
		logic             no_reference;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]                  frame_len;
		logic signed [FEATURE_W-1:0] base_value;
		logic                        alternating;
		logic [STEP_W-1:0]           step;
		logic                        typed;
		frame_result_t               want;
	} frame_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	frcad_feature_if feat_ch();
	frcad_result_if res_ch();

	frame_rms_change_anomaly_detector_top #(
		.FRAME_FEATURES(FRAME_FEATURES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.feature(feat_ch),
		.result(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// detector state mirror
	logic signed [FEATURE_W-1:0] ref_frame [FRAME_FEATURES];
	bit have_ref;
	int feat_pos;
	logic [SUM_W-1:0] sq_sum;
	logic [STEP_W-1:0] gate_step;
	logic [STEP_W-1:0] hold_step;
	logic [TOTAL_W-1:0] anom_total;
	logic [RMS_W-1:0] threshold;

	frame_result_t expected_results[$];
	frame_result_t typed_results [int];
	int frames_done;
	int frames_sent;
	int mismatches;
	int items_sent;
	int src_idle_pct;
	int sink_idle_pct;
	int gen_pos;
	logic signed [FEATURE_W-1:0] last_sent [FRAME_FEATURES];
	longint step_base;
	frame_row_t directed_rows [DIRECTED_ROWS];

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = SUM_W / 2; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic bit update_detector(input logic signed [FEATURE_W-1:0] fv,
			input logic last, input logic [STEP_W-1:0] step, output frame_result_t r);
		longint diff;
		longint unsigned total;
		longint unsigned root;
		logic [RMS_W-1:0] rms;
		logic hit;
		r = '0;
		rms = '0;
		hit = 1'b0;
		if (feat_pos < FRAME_FEATURES) begin
			if (have_ref) begin
				diff = longint'(fv) - longint'(ref_frame[feat_pos]);
				total = 64'(sq_sum) + 64'(diff * diff);
				sq_sum = (total > SQ_SUM_MAX) ? SQ_SUM_MAX[SUM_W-1:0] : total[SUM_W-1:0];
			end
			ref_frame[feat_pos] = fv;
			feat_pos++;
		end
		if (!last)
			return 1'b0;
		if (have_ref) begin
			root = floor_sqrt(64'(sq_sum) >> MEAN_SHIFT);
			rms = (root > 64'hFFFF) ? '1 : root[RMS_W-1:0];
			if (rms > threshold && longint'(step) - longint'(gate_step) > GATE_SPAN) begin
				gate_step = step;
				if (longint'(step) - longint'(hold_step) >= HOLDOFF_SPAN &&
						anom_total <= CAP_TOTAL && step >= EARLY_STEP && rms >= MIN_ERROR) begin
					hold_step = step;
					anom_total++;
					hit = 1'b1;
				end
			end
		end
		r.rms_error = rms;
		r.anomaly = hit;
		r.no_reference = !have_ref;
		have_ref = 1'b1;
		feat_pos = 0;
		sq_sum = '0;
		return 1'b1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : monitor
		frame_result_t got;
		frame_result_t want;
		if (arst_n && feat_ch.valid && feat_ch.ready) begin
			if (update_detector(feat_ch.feature_value, feat_ch.frame_end,
					feat_ch.step_count, got)) begin
				if (typed_results.exists(frames_done))
					got = typed_results[frames_done];
				expected_results.insert(expected_results.size(), got);
				frames_done++;
			end
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no frame pending: rms_error %0d", res_ch.rms_error);
				mismatches++;
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (res_ch.rms_error !== want.rms_error) begin
					$error("rms_error: expected %0d, actual %0d", want.rms_error, res_ch.rms_error);
					mismatches++;
				end
				if (res_ch.anomaly !== want.anomaly) begin
					$error("anomaly: expected %0d, actual %0d", want.anomaly, res_ch.anomaly);
					mismatches++;
				end
				if (res_ch.no_reference !== want.no_reference) begin
					$error("no_reference: expected %0d, actual %0d", want.no_reference,
						res_ch.no_reference);
					mismatches++;
				end
			end
		end
	end

	task automatic send_feature(input logic signed [FEATURE_W-1:0] fv, input logic last,
			input logic [STEP_W-1:0] step);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			feat_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feat_ch.valid <= 1'b1;
		feat_ch.feature_value <= fv;
		feat_ch.frame_end <= last;
		feat_ch.step_count <= step;
		do @(posedge clk); while (!feat_ch.ready);
		if (gen_pos < FRAME_FEATURES) begin
			last_sent[gen_pos] = fv;
			items_sent++;
		end else if (last) begin
			items_sent++;
		end
		gen_pos = last ? 0 : gen_pos + 1;
	endtask

	task automatic random_frame();
		int len;
		int mode;
		int span;
		int pick;
		int v;
		longint s;
		logic signed [FEATURE_W-1:0] fv;
		pick = $urandom_range(99);
		if (pick < 70)
			len = $urandom_range(1, 8);
		else if (pick < 90)
			len = $urandom_range(9, 32);
		else if (pick < 98)
			len = FRAME_FEATURES;
		else
			len = $urandom_range(FRAME_FEATURES + 1, FRAME_FEATURES + 6);
		mode = $urandom_range(9);
		span = $urandom_range(1, 300);
		if ($urandom_range(99) < 5) begin
			s = step_base - longint'($urandom_range(200));
			if (s < 0)
				s = 0;
		end else begin
			step_base += longint'($urandom_range(160));
			if (step_base > STEP_LIMIT)
				step_base = STEP_LIMIT;
			s = step_base;
		end
		for (int i = 0; i < len; i++) begin
			if (i >= FRAME_FEATURES || (mode >= 4 && mode <= 7)) begin
				fv = FEATURE_W'($urandom);
			end else if (mode == 8) begin
				fv = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			end else if (mode == 9) begin
				fv = last_sent[i];
			end else begin
				v = int'(last_sent[i]) + int'($urandom_range(2 * span)) - span;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				fv = FEATURE_W'(v);
			end
			send_feature(fv, i == len - 1, STEP_W'(s));
		end
		frames_sent++;
	endtask

	task automatic drain();
		feat_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == THRESHOLD_ADDR)
			threshold = data[RMS_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(threshold)) begin
			$error("error_threshold: expected %0d, actual %0d", threshold, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int seg_start;
		int seg_frames;
		logic [RMS_W-1:0] seg_threshold [SEGMENTS];
		directed_rows = '{
			'{8'd66, 16'sh8000, 1'b0, 31'd0, 1'b1, '{16'd0, 1'b0, 1'b1}},
			'{8'd4, 16'sh8000, 1'b0, 31'd5, 1'b1, '{16'd0, 1'b0, 1'b0}},
			'{8'd64, 16'sh7FFF, 1'b0, 31'd60, 1'b1, '{16'd65535, 1'b0, 1'b0}},
			'{8'd1, 16'sh8000, 1'b0, 31'd90, 1'b0, '0},
			'{8'd3, 16'sh7FFF, 1'b0, 31'd400, 1'b0, '0},
			'{8'd8, 16'sd256, 1'b1, 31'd420, 1'b0, '0},
			'{8'd8, -16'sd256, 1'b1, 31'd300, 1'b0, '0},
			'{8'd8, 16'sd1000, 1'b0, 31'd450, 1'b0, '0},
			'{8'd8, -16'sd1000, 1'b0, 31'd501, 1'b0, '0},
			'{8'd8, 16'sd1000, 1'b0, 31'd560, 1'b0, '0}
		};
		seg_threshold = '{16'hFFFF, 16'd0, 16'($urandom_range(130, 2000)),
			16'($urandom), 16'd128, 16'($urandom_range(600))};
		have_ref = 1'b0;
		feat_pos = 0;
		sq_sum = '0;
		gate_step = '0;
		hold_step = '0;
		anom_total = '0;
		threshold = THRESH_RESET;
		frames_done = 0;
		frames_sent = 0;
		mismatches = 0;
		items_sent = 0;
		gen_pos = 0;
		step_base = 600;
		src_idle_pct = 14;
		sink_idle_pct = 88;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		feat_ch.valid = 1'b0;
		feat_ch.feature_value = '0;
		feat_ch.frame_end = 1'b0;
		feat_ch.step_count = '0;
		res_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read(THRESHOLD_ADDR);

		for (int k = 0; k < DIRECTED_ROWS; k++) begin
			if (directed_rows[k].typed)
				typed_results[frames_sent] = directed_rows[k].want;
			for (int i = 0; i < directed_rows[k].frame_len; i++)
				send_feature((directed_rows[k].alternating && i[0]) ?
					-directed_rows[k].base_value : directed_rows[k].base_value,
					i == directed_rows[k].frame_len - 1, directed_rows[k].step);
			frames_sent++;
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			src_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 88 : 0;
			sink_idle_pct = (seg < 2) ? 88 : (seg < 4) ? 14 : 0;
			apb_write(THRESHOLD_ADDR, {DATA_W'($urandom) >> RMS_W << RMS_W} | seg_threshold[seg]);
			if (seg == 0)
				apb_write(UNUSED_ADDR, DATA_W'($urandom));
			apb_read(THRESHOLD_ADDR);
			if (seg == 4)
				step_base = HIGH_STEP_BASE;
			seg_start = items_sent;
			seg_frames = 0;
			while (items_sent - seg_start < SEGMENT_ITEMS || seg_frames < SEGMENT_FRAMES) begin
				random_frame();
				seg_frames++;
			end
		end

		drain();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
